/* hdl/gregorian_date_difference_unit_macros.svh */
// assertion macros for the gregorian date difference unit checker
// depends on clk_i and rst_ni being visible in the using scope
`ifndef GREGORIAN_DATE_DIFFERENCE_UNIT_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_UNIT_MACROS_SVH

// antecedent implies consequent, checked out of reset
`define GDDU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// expression holds at every edge out of reset
`define GDDU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

/* hdl/gddu_pkg.sv */
// shared types, constants and the month table of the date difference unit
// no dependencies
`default_nettype none

package gddu_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned DIFF_W    = 23;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned DAY_NUM_W = 23;
  localparam int unsigned ORD_W     = 9;
  localparam int unsigned LEAPS_W   = 13;

  // reciprocal of 100 scaled by 2^19, exact for operands below 43690
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // day number of 1970-01-01 (a thursday) is 5 below a multiple of 7 plus 4
  localparam logic [5:0] WDAY_OFFSET = 6'd5;
  localparam logic [2:0] WDAY_MOD    = 3'd7;

  localparam logic signed [DIFF_W:0] DIFF_MAX = 24'sd4194303;
  localparam logic signed [DIFF_W:0] DIFF_MIN = -24'sd4194304;

  typedef struct packed {
    logic [YEAR_W-1:0]  from_year;
    logic [MONTH_W-1:0] from_month;
    logic [DAY_W-1:0]   from_day;
    logic [YEAR_W-1:0]  to_year;
    logic [MONTH_W-1:0] to_month;
    logic [DAY_W-1:0]   to_day;
  } date_pair_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic [WDAY_W-1:0]        weekday;
    logic                     bad_date;
  } result_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // control bits that ride along with a beat through the pipeline
  typedef struct packed {
    logic valid;
    logic bad;
  } pipe_ctl_t;

  // days in the year before the first of the given month (non-leap)
  function automatic logic [ORD_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/gddu_day_number.sv */
// three-stage pipeline mapping one date to its linear day number
// depends on gddu_pkg
`default_nettype none

module gddu_day_number import gddu_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pipe_ctl_t            ctl_i,
  input  wire date_t                date_i,
  output pipe_ctl_t                 ctl_o,
  output logic [DAY_NUM_W-1:0]      day_num_o
);

  // stage 1: reciprocal products for the century and 400-year counts
  pipe_ctl_t          ctl1_q;
  logic [YEAR_W-1:0]  year1_q;
  logic [MONTH_W-1:0] month1_q;
  logic [DAY_W-1:0]   day1_q;
  logic [27:0]        p100_d, p100_q;
  logic [25:0]        p400_d, p400_q;
  logic [14:0]        y_p99, y_p399;

  always_comb begin
    y_p99  = {1'b0, date_i.year} + 15'd99;
    y_p399 = {1'b0, date_i.year} + 15'd399;
    p100_d = 28'(y_p99) * 28'(RECIP_100);
    p400_d = 26'(y_p399[14:2]) * 26'(RECIP_100);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    year1_q  <= date_i.year;
    month1_q <= date_i.month;
    day1_q   <= date_i.day;
    p100_q   <= p100_d;
    p400_q   <= p400_d;
  end

  // stage 2: leap test, leap days before the year, year days, ordinal day
  pipe_ctl_t            ctl2_q;
  logic [7:0]           c100;
  logic [5:0]           c400;
  logic [12:0]          q4;
  logic [14:0]          yr_ext;
  logic                 div100, div400, leap;
  logic [13:0]          leaps_full;
  logic [DAY_NUM_W-1:0] yd_d, yd2_q;
  logic [LEAPS_W-1:0]   leaps2_q;
  logic [ORD_W-1:0]     ord_d, ord2_q;

  always_comb begin
    // ceilings of year/100 and year/400
    c100       = p100_q[DIV100_SHIFT+7:DIV100_SHIFT];
    c400       = p400_q[DIV100_SHIFT+5:DIV100_SHIFT];
    yr_ext     = {1'b0, year1_q};
    q4         = 13'(({1'b0, year1_q} + 15'd3) >> 2);
    div100     = (15'(c100) * 15'd100) == yr_ext;
    div400     = (15'(c400) * 15'd400) == yr_ext;
    leap       = div400 || ((year1_q[1:0] == 2'b00) && !div100);
    leaps_full = {1'b0, q4} - {6'b0, c100} + {8'b0, c400};
    yd_d       = DAY_NUM_W'(year1_q) * 23'd365;
    ord_d      = days_before_month(month1_q) + ORD_W'(day1_q)
               + ORD_W'((month1_q > MONTH_FEB) && leap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yd2_q    <= yd_d;
    leaps2_q <= leaps_full[LEAPS_W-1:0];
    ord2_q   <= ord_d;
  end

  // stage 3: final sum
  pipe_ctl_t            ctl3_q;
  logic [DAY_NUM_W-1:0] num3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else begin
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num3_q <= yd2_q + DAY_NUM_W'(leaps2_q) + DAY_NUM_W'(ord2_q);
  end

  assign ctl_o     = ctl3_q;
  assign day_num_o = num3_q;

endmodule

`default_nettype wire

/* hdl/gregorian_date_difference_unit.sv */
// top level: two day-number pipelines, difference and weekday stages
// depends on gddu_pkg and gddu_day_number
`default_nettype none

// Takes one date pair per clock and returns the signed day difference
// (to minus from), the weekday of the second date (0 = sunday) and a bad
// date flag. A pair is taken on any clock edge with start high; busy is
// never raised. Every result appears on res_o for exactly one cycle with
// done_o high, in order, once its pair has passed the stages below. The
// receiver cannot hold a result off and must take each beat as it comes.
// Each pair passes through three day-number stages (reciprocal multiply, leap
// and year product, sum), one difference stage and the output register.
// A month outside 1..12 or a day of 0 gives bad_date with zero results.
// The difference saturates to the 23-bit signed range.
module gregorian_date_difference_unit import gddu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire date_pair_t req_i,
  output logic            done_o,
  output result_t         res_o
);

  // the pipeline never stalls
  assign busy = 1'b0;

  // accept and range check
  pipe_ctl_t ctl_in;
  date_t     from_date, to_date;

  always_comb begin
    ctl_in.valid = start && !busy;
    ctl_in.bad   = (req_i.from_month < MONTH_JAN) || (req_i.from_month > MONTH_DEC)
                || (req_i.to_month < MONTH_JAN) || (req_i.to_month > MONTH_DEC)
                || (req_i.from_day == '0) || (req_i.to_day == '0);
    from_date    = '{year: req_i.from_year, month: req_i.from_month, day: req_i.from_day};
    to_date      = '{year: req_i.to_year, month: req_i.to_month, day: req_i.to_day};
  end

  // day numbers of both dates
  pipe_ctl_t            ctl3;
  logic [DAY_NUM_W-1:0] from_num, to_num;

  gddu_day_number u_from_num (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_in),
    .date_i    (from_date),
    .ctl_o     (),
    .day_num_o (from_num)
  );

  gddu_day_number u_to_num (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_in),
    .date_i    (to_date),
    .ctl_o     (ctl3),
    .day_num_o (to_num)
  );

  // stage 4: saturated difference and octal digit sum for mod 7
  pipe_ctl_t                ctl4_q;
  logic signed [DIFF_W:0]   diff_full;
  logic signed [DIFF_W-1:0] diff_d, diff4_q;
  logic [23:0]              num_pad;
  logic [5:0]               dsum_d, dsum4_q;

  always_comb begin
    diff_full = $signed({1'b0, to_num}) - $signed({1'b0, from_num});
    if (diff_full > DIFF_MAX) begin
      diff_d = DIFF_MAX[DIFF_W-1:0];
    end else if (diff_full < DIFF_MIN) begin
      diff_d = DIFF_MIN[DIFF_W-1:0];
    end else begin
      diff_d = diff_full[DIFF_W-1:0];
    end
    // 8 == 1 mod 7, so the octal digits sum to the same residue
    num_pad = {1'b0, to_num};
    dsum_d  = '0;
    for (int i = 0; i < 8; i++) begin
      dsum_d = dsum_d + 6'(num_pad[3*i +: 3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl3;
    end
  end

  always_ff @(posedge clk_i) begin
    diff4_q <= diff_d;
    dsum4_q <= dsum_d;
  end

  // stage 5: fold the residue and register the result beat
  logic [5:0]        wd_t;
  logic [3:0]        wd_u, wd_v;
  logic [WDAY_W-1:0] wday;
  result_t           res_d, res_q;
  logic              done_q;

  always_comb begin
    wd_t = dsum4_q + WDAY_OFFSET;
    wd_u = 4'(wd_t[5:3]) + 4'(wd_t[2:0]);
    wd_v = 4'(wd_u[3]) + 4'(wd_u[2:0]);
    if (wd_v >= 4'(WDAY_MOD)) begin
      wday = WDAY_W'(wd_v - 4'(WDAY_MOD));
    end else begin
      wday = wd_v[WDAY_W-1:0];
    end
    if (ctl4_q.bad) begin
      res_d = '{day_difference: '0, weekday: '0, bad_date: 1'b1};
    end else begin
      res_d = '{day_difference: diff4_q, weekday: wday, bad_date: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* hdl/gddu_checker.sv */
// port-level checker for the date difference unit, bound to the top level
// depends on gddu_pkg and the assertion macro header
`default_nettype none

`include "gregorian_date_difference_unit_macros.svh"

module gddu_checker import gddu_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire date_pair_t req_i,
  input wire logic       done_o,
  input wire result_t    res_o
);

  // every accepted beat is followed by its result beat
  `GDDU_ASSERT_IMPL(a_accept_to_done, start && !busy, ##5 done_o, "accepted beat gave no result")

  // no result beat without a matching accepted beat
  `GDDU_ASSERT_IMPL(a_done_has_source, done_o, $past(start && !busy, 5), "result beat out of nowhere")

  // a flagged beat carries zero results
  `GDDU_ASSERT_IMPL(a_bad_zeroes, done_o && res_o.bad_date,
                    res_o.day_difference == '0 && res_o.weekday == '0, "bad beat not zeroed")

  // weekday stays within sunday..saturday
  `GDDU_ASSERT_IMPL(a_weekday_range, done_o, res_o.weekday != 3'd7, "weekday out of range")

  // a day of zero in the first date is always flagged
  `GDDU_ASSERT_IMPL(a_zero_day_flag, start && !busy && req_i.from_day == '0,
                    ##5 res_o.bad_date, "zero day not flagged")

endmodule

bind gregorian_date_difference_unit gddu_checker u_gddu_checker (.*);

`default_nettype wire
